// ===== rtl/grr_pkg.sv =====
// Shared types and constants for the group reverse reorder block.
package grr_pkg;

   localparam int VALUE_WIDTH       = 32;
   localparam int CFG_WIDTH         = 7;
   localparam int MAX_GROUP_DEFAULT = 64;

   localparam logic [CFG_WIDTH-1:0] GROUP_SIZE_RESET = CFG_WIDTH'(2);
   localparam logic [CFG_WIDTH-1:0] GROUP_SIZE_MIN   = CFG_WIDTH'(2);

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] item_value;
      logic                          list_end;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] out_value;
      logic                          run_last;
      logic                          list_done;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          list_end;
      logic                          reverse;
      logic [CFG_WIDTH-1:0]          count;
   } cmd_type;

   typedef struct packed {
      logic                          en;
      logic [CFG_WIDTH-1:0]          addr;
      logic signed [VALUE_WIDTH-1:0] data;
   } wr_type;

endpackage

// ===== rtl/grr_front.sv =====
// Front end: accepts requests, holds the group size, classifies and buffers values.
module grr_front #(
   parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  grr_pkg::req_type               req,
   input  logic                           csr_we,
   input  logic [grr_pkg::CFG_WIDTH-1:0]  csr_wdata,
   input  logic                           cmd_empty,
   output logic                           cmd_push,
   output grr_pkg::cmd_type               cmd,
   output grr_pkg::wr_type                wr
);
   import grr_pkg::*;

   localparam logic [CFG_WIDTH-1:0] K_MAX = CFG_WIDTH'(MAX_GROUP);

   logic [CFG_WIDTH-1:0] group_size_ff, group_size_in;
   logic [CFG_WIDTH-1:0] fill_ff, fill_in;
   logic [CFG_WIDTH-1:0] k;
   logic [CFG_WIDTH:0]   total;
   logic                 accept, is_group, is_forward;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GROUP_SIZE_RESET;
         fill_ff       <= '0;
      end else begin
         group_size_ff <= group_size_in;
         fill_ff       <= fill_in;
      end
   end

   always_comb begin
      group_size_in = csr_we ? csr_wdata : group_size_ff;
      k          = (group_size_ff > K_MAX) ? K_MAX : group_size_ff;
      total      = {1'b0, fill_ff} + (CFG_WIDTH+1)'(1);
      req_ready  = cmd_empty;
      accept     = req_valid && req_ready;
      is_group   = (k >= GROUP_SIZE_MIN) && (total >= {1'b0, k});
      is_forward = !is_group && (req.list_end || (k < GROUP_SIZE_MIN));
      cmd_push   = accept && (is_group || is_forward);

      cmd.value    = req.item_value;
      cmd.list_end = req.list_end;
      cmd.reverse  = is_group;
      cmd.count    = fill_ff;

      wr.en   = accept && !cmd_push;
      wr.addr = fill_ff;
      wr.data = req.item_value;

      fill_in = fill_ff;
      if (accept) begin
         fill_in = cmd_push ? '0 : total[CFG_WIDTH-1:0];
      end
   end

endmodule

// ===== rtl/grr_queue.sv =====
// Two-entry command queue between the front and back ends.
module grr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  grr_pkg::cmd_type push_data,
   input  logic             pop,
   output grr_pkg::cmd_type head,
   output logic             empty
);
   import grr_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      empty     = (count_ff == 2'd0);
      do_push   = push && (count_ff != 2'd2);
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      head      = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/grr_back.sv =====
// Back end: group buffer, read sequencer and response output register.
module grr_back #(
   parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  grr_pkg::wr_type  wr,
   input  logic             cmd_valid,
   input  grr_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output grr_pkg::rsp_type rsp
);
   import grr_pkg::*;

   localparam int FW = $clog2(MAX_GROUP);

   logic signed [VALUE_WIDTH-1:0] mem [MAX_GROUP];

   logic [CFG_WIDTH-1:0]          pos_ff, pos_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [VALUE_WIDTH-1:0] s1_data_ff;
   logic                          s1_last_ff, s1_done_ff;
   logic                          out_valid_ff, out_valid_in;
   rsp_type                       out_ff;
   logic                          s2_adv, issue, last, use_value;
   logic [CFG_WIDTH-1:0]          addr_full;
   logic [FW-1:0]                 rd_addr;

   always_comb begin
      last      = (pos_ff == cmd.count);
      s2_adv    = !out_valid_ff || rsp_ready;
      issue     = cmd_valid && (!s1_valid_ff || s2_adv);
      cmd_pop   = issue && last;
      use_value = cmd.reverse ? (pos_ff == '0) : last;
      addr_full = cmd.reverse ? (cmd.count - pos_ff) : pos_ff;
      rd_addr   = addr_full[FW-1:0];

      pos_in = pos_ff;
      if (issue) begin
         pos_in = last ? '0 : pos_ff + CFG_WIDTH'(1);
      end

      s1_valid_in = s1_valid_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (s2_adv) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = s2_adv ? s1_valid_ff : out_valid_ff;
      rsp_valid    = out_valid_ff;
      rsp          = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[FW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_data_ff <= use_value ? cmd.value : mem[rd_addr];
         s1_last_ff <= last;
         s1_done_ff <= last && cmd.list_end;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_ff.out_value <= s1_data_ff;
         out_ff.run_last  <= s1_last_ff;
         out_ff.list_done <= s1_done_ff;
      end
   end

endmodule

// ===== rtl/group_reverse_reorder_core.sv =====
// Top level of the group reverse reorder block.
//
// Requests carry one list value and an end-of-list mark on a valid/ready
// channel; responses leave on a valid/ready channel, each marked with
// run_last (last response of its request) and list_done (end of the list).
// The user must write the group size through csr_we/csr_wdata only while
// the block idles; the block itself does not enforce it. A request that
// is only buffered yields no response. A request that completes a group,
// ends the list or passes through yields count+1 responses, one per cycle
// while rsp_ready stays high, the first passing through the command queue,
// the read stage and the output register. No request is accepted until the
// back end has read every buffered value of the pending command.
// Reset clears the fill count, the command queue and the output stage and
// sets the group size to 2. When the receiver stalls, the output register
// and one read stage hold, and the sequencer waits.
module group_reverse_reorder_core #(
   parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  grr_pkg::req_type              req,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output grr_pkg::rsp_type              rsp,
   input  logic                          csr_we,
   input  logic [grr_pkg::CFG_WIDTH-1:0] csr_wdata
);
   import grr_pkg::*;

   logic    cmd_push, cmd_pop, cmd_empty;
   cmd_type cmd_in, cmd_head;
   wr_type  wr;

   grr_front #(.MAX_GROUP(MAX_GROUP)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd_push  (cmd_push),
      .cmd       (cmd_in),
      .wr        (wr)
   );

   grr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   grr_back #(.MAX_GROUP(MAX_GROUP)) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.list_done) |-> rsp.run_last)
      else $error("list_done without run_last");

   a_push_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> cmd_empty)
      else $error("command pushed while another is pending");

   a_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> cmd_empty)
      else $error("buffer written while back end reads it");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command popped from empty queue");

endmodule

// ===== test/tb_top.sv =====
// Testbench for group_reverse_reorder_core: directed and random lists checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import grr_pkg::*;

   localparam int MAX_GROUP  = 64;
   localparam int RANDOM_REQ = 310;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp;
   logic                 csr_we = 1'b0;
   logic [CFG_WIDTH-1:0] csr_wdata = '0;

   logic [CFG_WIDTH-1:0]   group_size_q;
   logic [VALUE_WIDTH-1:0] held_values [MAX_GROUP];
   int                     held_count;
   rsp_type                expected_rsp [$];

   int          requests_sent;
   int          responses_seen;
   int          mismatch_count;
   int          phase_count;
   bit          req_idle_on;
   bit          rsp_idle_on;
   int          stall_left;
   int unsigned stall_roll;

   group_reverse_reorder_core #(.MAX_GROUP(MAX_GROUP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int effective_size(logic [CFG_WIDTH-1:0] size);
      return (int'(size) > MAX_GROUP) ? MAX_GROUP : int'(size);
   endfunction

   function automatic rsp_type make_rsp(logic [VALUE_WIDTH-1:0] value, bit last, bit done);
      rsp_type r;
      r.out_value = value;
      r.run_last  = last;
      r.list_done = done;
      return r;
   endfunction

   task automatic queue_expected(input rsp_type r);
      expected_rsp.insert(expected_rsp.size(), r);
   endtask

   task automatic reorder_predict(input req_type item);
      int  k;
      int  n;
      int  total;
      bit  last;
      k     = effective_size(group_size_q);
      n     = held_count;
      total = n + 1;
      if (k >= 2 && total >= k) begin
         queue_expected(make_rsp(item.item_value, total == 1,
                                 item.list_end && total == 1));
         for (int i = 1; i < total; i++) begin
            last = (i == total - 1);
            queue_expected(make_rsp(held_values[n-i], last, item.list_end && last));
         end
         held_count = 0;
      end else if (item.list_end || k < 2) begin
         for (int i = 0; i < n; i++)
            queue_expected(make_rsp(held_values[i], 1'b0, 1'b0));
         queue_expected(make_rsp(item.item_value, 1'b1, item.list_end));
         held_count = 0;
      end else begin
         held_values[n] = item.item_value;
         held_count     = total;
      end
   endtask

   function automatic int pick_gap();
      int unsigned r;
      if (!req_idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Call at a rising edge; returns at a rising edge.
   task automatic send_request(input logic [VALUE_WIDTH-1:0] value, input bit last);
      req_type item;
      int      gap;
      item.item_value = value;
      item.list_end   = last;
      req_valid <= 1'b1;
      req       <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      requests_sent++;
      reorder_predict(item);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_group_size(input logic [CFG_WIDTH-1:0] size);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_we       <= 1'b0;
      group_size_q  = size;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (rsp_idle_on && stall_roll < 25) begin
            rsp_ready <= 1'b0;
            if (stall_roll < 22)
               stall_left <= $urandom_range(0, 3);
            else
               stall_left <= $urandom_range(10, 40);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         responses_seen++;
         if (expected_rsp.size() == 0) begin
            $error("unexpected response: out_value %h run_last %b list_done %b",
                   rsp.out_value, rsp.run_last, rsp.list_done);
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp.out_value !== want.out_value) begin
               $error("out_value: expected %h, got %h", want.out_value, rsp.out_value);
               mismatch_count++;
            end
            if (rsp.run_last !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp.run_last);
               mismatch_count++;
            end
            if (rsp.list_done !== want.list_done) begin
               $error("list_done: expected %b, got %b", want.list_done, rsp.list_done);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_default_pairs();
      send_request(32'h8000_0000, 1'b0);
      send_request(32'h7fff_ffff, 1'b1);
      send_request(32'h0000_0000, 1'b0);
      send_request(32'hffff_ffff, 1'b0);
      send_request(32'h5555_5555, 1'b1);
   endtask

   task automatic test_pass_through();
      set_group_size(7'd0);
      send_request(32'haaaa_aaaa, 1'b0);
      send_request(32'h0000_0001, 1'b1);
      send_request(32'hffff_fffe, 1'b0);
      set_group_size(7'd1);
      send_request(32'h1234_5678, 1'b0);
      send_request(32'h8765_4321, 1'b1);
      // drain held values through pass mode
      set_group_size(7'd6);
      send_request(32'h0000_0011, 1'b0);
      send_request(32'h0000_0022, 1'b0);
      set_group_size(7'd0);
      send_request(32'h0000_0033, 1'b0);
   endtask

   task automatic test_size_lowered();
      set_group_size(7'd8);
      for (int i = 0; i < 4; i++)
         send_request(32'h0100_0000 + i, 1'b0);
      set_group_size(7'd3);
      send_request(32'h0100_0004, 1'b0);
   endtask

   task automatic test_oversize_early_end();
      set_group_size(7'd100);
      send_request(32'h0bad_0001, 1'b0);
      send_request(32'h0bad_0002, 1'b0);
      send_request(32'h0bad_0003, 1'b1);
   endtask

   task automatic test_random_lists();
      logic [CFG_WIDTH-1:0] plan [16] = '{7'd3, 7'd2, 7'd0, 7'd5, 7'd1, 7'd64, 7'd4, 7'd127,
                                          7'd7, 7'd2, 7'd16, 7'd6, 7'd100, 7'd3, 7'd1, 7'd9};
      logic [CFG_WIDTH-1:0] size;
      int                   stop_at;
      int                   k;
      int                   budget;
      int                   in_phase;
      int                   len;
      bit                   first_list;
      stop_at = requests_sent + RANDOM_REQ;
      while (requests_sent < stop_at) begin
         if (phase_count < 16)
            size = plan[phase_count];
         else if ($urandom_range(0, 99) < 80)
            size = CFG_WIDTH'($urandom_range(0, 8));
         else
            size = CFG_WIDTH'($urandom_range(0, 127));
         set_group_size(size);
         req_idle_on = (phase_count % 4 != 0);
         rsp_idle_on = (phase_count % 4 != 0);
         k          = effective_size(size);
         budget     = (k >= 16) ? k + 8 : 40;
         in_phase   = 0;
         first_list = 1'b1;
         while (in_phase < budget && requests_sent < stop_at) begin
            if (first_list && k == MAX_GROUP)
               len = MAX_GROUP;
            else if (k >= 16)
               len = $urandom_range(1, k + 4);
            else
               len = $urandom_range(1, 2 * ((k < 1) ? 1 : k) + 2);
            first_list = 1'b0;
            for (int i = 0; i < len && in_phase < budget && requests_sent < stop_at; i++) begin
               send_request(rand_value(), i == len - 1);
               in_phase++;
            end
         end
         phase_count++;
      end
   endtask

   initial begin
      group_size_q   = GROUP_SIZE_RESET;
      held_count     = 0;
      requests_sent  = 0;
      responses_seen = 0;
      mismatch_count = 0;
      phase_count    = 0;
      req_idle_on    = 1'b1;
      rsp_idle_on    = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_pairs();
      test_pass_through();
      test_size_lowered();
      test_oversize_early_end();
      test_random_lists();
      wait_idle();
      repeat (20) @(posedge clock);
      $display("Summary: %0d requests over %0d random group-size phases plus directed cases",
               requests_sent, phase_count);
      $display("Summary: %0d responses compared, %0d field mismatches",
               responses_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/grr_pkg.sv
rtl/grr_front.sv
rtl/grr_queue.sv
rtl/grr_back.sv
rtl/group_reverse_reorder_core.sv
test/tb_top.sv
